// ----- hdl/pcps_pkg.sv -----
// Shared constants, codes, types and address helper for the column pair scorer.
`default_nettype none

package pcps_pkg;

	// Sizing of the lanes and tables
	localparam int MAX_FEATURES  = 4;
	localparam int ALPHABET_SIZE = 20;

	// Fixed field widths
	localparam int LETTER_W    = 5;
	localparam int COL_W       = 20;
	localparam int KIND_W      = 3;
	localparam int FEAT_W      = 2;
	localparam int VALUE_W     = 16;
	localparam int WEIGHT_W    = 16;
	localparam int NUM_WEIGHTS = 4;
	localparam int FC_W        = 3;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int SCORE_W     = 34;

	// Arithmetic widths: signed Q8.8 times unsigned Q2.14, then the lane sum
	localparam int PROD_W = VALUE_W + WEIGHT_W + 1;
	localparam int SUM_W  = SCORE_W + $clog2(MAX_FEATURES);

	// Per-lane table store: odds triangle, prob triangle, insertion row
	localparam int PAIR_DEPTH = ALPHABET_SIZE * ALPHABET_SIZE;
	localparam int LANE_DEPTH = 2 * PAIR_DEPTH + ALPHABET_SIZE;
	localparam int ADDR_W     = $clog2(LANE_DEPTH);

	// Reset values of the registers
	localparam logic [FC_W-1:0]     FC_RESET     = FC_W'(1);
	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(16384);

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD_ODDS    = 3'd0,
		KIND_LOAD_PROB    = 3'd1,
		KIND_LOAD_INSERT  = 3'd2,
		KIND_SCORE_ODDS   = 3'd3,
		KIND_SCORE_PROB   = 3'd4,
		KIND_SCORE_INSERT = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		REGION_ODDS   = 2'd0,
		REGION_PROB   = 2'd1,
		REGION_INSERT = 2'd2
	} region_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FEATURE_COUNT = 3'd0,
		REG_WEIGHT_0      = 3'd1,
		REG_WEIGHT_1      = 3'd2,
		REG_WEIGHT_2      = 3'd3,
		REG_WEIGHT_3      = 3'd4
	} cfg_reg_t;

	// Access request into one lane's table store
	typedef struct packed {
		logic               rd_en;
		logic               wr_en;
		logic [ADDR_W-1:0]  addr;
		logic [VALUE_W-1:0] wr_data;
		logic               active;
	} lane_req_t;

	// Stage advance enables shared by the lanes
	typedef struct packed {
		logic s1;
		logic s2;
	} stage_en_t;

	// Pair tables are symmetric, so only the entry [lo][hi] is stored
	function automatic logic [ADDR_W-1:0] lane_addr(region_t region,
			logic [LETTER_W-1:0] a, logic [LETTER_W-1:0] b);
		logic [LETTER_W-1:0] lo;
		logic [LETTER_W-1:0] hi;
		logic [ADDR_W-1:0]   tri_ofs;
		lo      = (a < b) ? a : b;
		hi      = (a < b) ? b : a;
		tri_ofs = ADDR_W'(lo) * ADDR_W'(ALPHABET_SIZE) + ADDR_W'(hi);
		unique case (region)
			REGION_ODDS:   lane_addr = tri_ofs;
			REGION_PROB:   lane_addr = ADDR_W'(PAIR_DEPTH) + tri_ofs;
			REGION_INSERT: lane_addr = ADDR_W'(2 * PAIR_DEPTH) + ADDR_W'(a);
			default:       lane_addr = '0;
		endcase
	endfunction

	// Table region that a transaction kind addresses
	function automatic region_t kind_region(logic [KIND_W-1:0] kind);
		unique case (kind)
			KIND_LOAD_ODDS, KIND_SCORE_ODDS: kind_region = REGION_ODDS;
			KIND_LOAD_PROB, KIND_SCORE_PROB: kind_region = REGION_PROB;
			default:                         kind_region = REGION_INSERT;
		endcase
	endfunction

endpackage

`default_nettype wire

// ----- hdl/pcps_in_if.sv -----
// Input channel: table loads and score requests.
`default_nettype none

interface pcps_in_if import pcps_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [COL_W-1:0]    column_x;
	logic [COL_W-1:0]    column_y;
	logic [FEAT_W-1:0]   load_feature;
	logic [LETTER_W-1:0] load_row;
	logic [LETTER_W-1:0] load_col;
	logic signed [VALUE_W-1:0] load_value;

	modport source (output valid, kind, column_x, column_y, load_feature, load_row,
		load_col, load_value, input ready);
	modport sink (input valid, kind, column_x, column_y, load_feature, load_row,
		load_col, load_value, output ready);
endinterface

`default_nettype wire

// ----- hdl/pcps_out_if.sv -----
// Output channel: one score per score request.
`default_nettype none

interface pcps_out_if import pcps_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [SCORE_W-1:0] score;
	logic                      bad_letter;

	modport source (output valid, score, bad_letter, input ready);
	modport sink (input valid, score, bad_letter, output ready);
endinterface

`default_nettype wire

// ----- hdl/profile_column_pair_scorer.sv -----
// Top level: register file, lane control, feature lanes and merge stage.
//
//  channel  direction  handshake         contents
//  cmd      in         valid/ready       kind, columns, table load fields
//  res      out        valid/ready       score, bad_letter
//  cfg      in         cfg_wr_en only    cfg_index, cfg_data
//
// One item per cycle while the output is not stalled; after acceptance a score is registered
// by the table lookup in the lane memories, the weight multiply, and the merge and output register.
// Loads write the addressed lane memory at acceptance and give no result.
// Reset clears control and registers only; table contents are undefined until loaded.
// A stalled output holds its result while empty stages behind it keep accepting.
`default_nettype none

module profile_column_pair_scorer import pcps_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	pcps_in_if.sink                    cmd,
	pcps_out_if.source                 res
);

	logic [FC_W-1:0]     fc_q;
	logic [WEIGHT_W-1:0] weight_q [NUM_WEIGHTS];

	stage_en_t             en;
	logic                  take;
	logic                  accept;
	logic                  is_score;
	logic                  is_load;
	logic                  load_row_ok;
	logic                  load_col_ok;
	region_t               region;
	logic [MAX_FEATURES-1:0] lane_bad;
	logic [MAX_FEATURES-1:0] lane_wr;
	logic                  v1_s1;
	logic                  bad_s1;
	logic                  v2_s2;
	logic                  bad_s2;
	logic signed [PROD_W-1:0] prod_s2 [MAX_FEATURES];

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q <= FC_RESET;
			for (int i = 0; i < NUM_WEIGHTS; i++) begin
				weight_q[i] <= WEIGHT_RESET;
			end
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_FEATURE_COUNT: fc_q        <= cfg_data[FC_W-1:0];
				REG_WEIGHT_0:      weight_q[0] <= cfg_data[WEIGHT_W-1:0];
				REG_WEIGHT_1:      weight_q[1] <= cfg_data[WEIGHT_W-1:0];
				REG_WEIGHT_2:      weight_q[2] <= cfg_data[WEIGHT_W-1:0];
				REG_WEIGHT_3:      weight_q[3] <= cfg_data[WEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// Decode the input transaction
	assign accept   = cmd.valid && cmd.ready;
	assign is_score = (cmd.kind == KIND_SCORE_ODDS) || (cmd.kind == KIND_SCORE_PROB)
		|| (cmd.kind == KIND_SCORE_INSERT);
	assign is_load  = (cmd.kind == KIND_LOAD_ODDS) || (cmd.kind == KIND_LOAD_PROB)
		|| (cmd.kind == KIND_LOAD_INSERT);
	assign load_row_ok = 32'(cmd.load_row) < ALPHABET_SIZE;
	assign load_col_ok = (cmd.kind == KIND_LOAD_INSERT)
		|| (32'(cmd.load_col) < ALPHABET_SIZE);
	assign region   = kind_region(cmd.kind);

	// Advance each stage when it is empty or the next one moves
	assign en.s2     = !v2_s2 || take;
	assign en.s1     = !v1_s1 || en.s2;
	assign cmd.ready = en.s1;

	for (genvar f = 0; f < MAX_FEATURES; f++) begin : g_lane
		logic [LETTER_W-1:0] x_f;
		logic [LETTER_W-1:0] y_f;
		logic [WEIGHT_W-1:0] w_f;
		logic                active_f;
		logic                ok_f;
		lane_req_t           req_f;

		// Pick this feature's letters; letters past the column read as zero
		if (LETTER_W * f + LETTER_W <= COL_W) begin : g_col
			assign x_f = cmd.column_x[LETTER_W*f +: LETTER_W];
			assign y_f = cmd.column_y[LETTER_W*f +: LETTER_W];
		end else begin : g_nocol
			assign x_f = '0;
			assign y_f = '0;
		end

		if (f < NUM_WEIGHTS) begin : g_w
			assign w_f = weight_q[f];
		end else begin : g_now
			assign w_f = '0;
		end

		assign active_f    = 32'(fc_q) > f;
		assign ok_f        = (32'(x_f) < ALPHABET_SIZE)
			&& ((cmd.kind == KIND_SCORE_INSERT) || (32'(y_f) < ALPHABET_SIZE));
		assign lane_bad[f] = active_f && !ok_f;
		assign lane_wr[f]  = accept && is_load && load_row_ok && load_col_ok
			&& (32'(cmd.load_feature) == f);

		// Build the lane request: a load writes, a score reads
		assign req_f.wr_en   = lane_wr[f];
		assign req_f.rd_en   = accept && is_score && active_f && ok_f;
		assign req_f.addr    = is_score ? lane_addr(region, x_f, y_f)
			: lane_addr(region, cmd.load_row, cmd.load_col);
		assign req_f.wr_data = cmd.load_value;
		assign req_f.active  = active_f;

		pcps_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.req     (req_f),
			.en      (en),
			.weight  (w_f),
			.prod_s2 (prod_s2[f])
		);
	end

	// Track score transactions through lookup and multiply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
		end else begin
			if (en.s1) begin
				v1_s1 <= accept && is_score;
			end
			if (en.s2) begin
				v2_s2 <= v1_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			bad_s1 <= |lane_bad;
		end
		if (en.s2) begin
			bad_s2 <= bad_s1;
		end
	end

	pcps_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.prod_s2  (prod_s2),
		.valid_s2 (v2_s2),
		.bad_s2   (bad_s2),
		.take     (take),
		.res      (res)
	);

	// A load never enters the score pipeline
	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !is_score |=> !v1_s1)
		else $error("load produced a pipeline entry");

	// A stalled stage-1 item stays put with its flag
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		v1_s1 && !en.s1 |=> v1_s1 && $stable(bad_s1))
		else $error("stage 1 item lost during stall");

	// A load writes at most one lane
	a_one_lane_wr: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(lane_wr))
		else $error("load wrote more than one lane");

	// Feature count write takes effect on the next cycle
	a_fc_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en && (cfg_index == REG_FEATURE_COUNT)
		|=> fc_q == $past(cfg_data[FC_W-1:0]))
		else $error("feature count write not taken");

endmodule

`default_nettype wire

// ----- hdl/pcps_ram.sv -----
// Generic single-clock RAM with one write port and a registered read port.
`default_nettype none

module pcps_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, and register the read data (held while re is low)
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/pcps_lane.sv -----
// One feature lane: table store, registered lookup and weight multiply.
`default_nettype none

module pcps_lane import pcps_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire lane_req_t             req,
	input  wire stage_en_t             en,
	input  wire logic [WEIGHT_W-1:0]   weight,
	output logic signed [PROD_W-1:0]   prod_s2
);

	logic [VALUE_W-1:0]         rdata_s1;
	logic                       active_s1;
	logic signed [VALUE_W-1:0]  value_s1;
	logic signed [WEIGHT_W:0]   weight_ext;
	logic signed [PROD_W-1:0]   prod_c;

	pcps_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (LANE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (req.wr_en),
		.waddr (req.addr),
		.wdata (req.wr_data),
		.re    (req.rd_en),
		.raddr (req.addr),
		.rdata (rdata_s1)
	);

	// Hold whether this lane counts for the item in stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_s1 <= 1'b0;
		end else if (en.s1) begin
			active_s1 <= req.active;
		end
	end

	// Multiply the Q8.8 entry by the unsigned Q2.14 weight
	assign value_s1   = $signed(rdata_s1);
	assign weight_ext = $signed({1'b0, weight});
	assign prod_c     = value_s1 * weight_ext;

	// Register the product; an idle lane adds nothing
	always_ff @(posedge clk) begin
		if (en.s2) begin
			prod_s2 <= active_s1 ? prod_c : '0;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/pcps_merge.sv -----
// Merge stage: sum the lane products, saturate, and hold the result transaction.
`default_nettype none

module pcps_merge import pcps_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic signed [PROD_W-1:0] prod_s2 [MAX_FEATURES],
	input  wire logic                valid_s2,
	input  wire logic                bad_s2,
	output logic                     take,
	pcps_out_if.source               res
);

	logic signed [SUM_W-1:0]   sum_c;
	logic [SUM_W-SCORE_W:0]    upper_c;
	logic                      ovf_c;
	logic signed [SCORE_W-1:0] score_c;
	logic                      valid_s3;
	logic signed [SCORE_W-1:0] score_s3;
	logic                      bad_s3;

	// Add the lanes
	always_comb begin
		sum_c = '0;
		for (int i = 0; i < MAX_FEATURES; i++) begin
			sum_c = sum_c + SUM_W'(prod_s2[i]);
		end
	end

	// Saturate to the score range; a bad letter forces zero
	assign upper_c = sum_c[SUM_W-1:SCORE_W-1];
	assign ovf_c   = !((&upper_c) || (~|upper_c));

	always_comb begin
		priority if (bad_s2) begin
			score_c = '0;
		end else if (ovf_c && sum_c[SUM_W-1]) begin
			score_c = {1'b1, {(SCORE_W-1){1'b0}}};
		end else if (ovf_c) begin
			score_c = {1'b0, {(SCORE_W-1){1'b1}}};
		end else begin
			score_c = sum_c[SCORE_W-1:0];
		end
	end

	// Output register: advance when empty or when the sink takes the result
	assign take = !valid_s3 || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (take) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			score_s3 <= score_c;
			bad_s3   <= bad_s2;
		end
	end

	assign res.valid      = valid_s3;
	assign res.score      = score_s3;
	assign res.bad_letter = bad_s3;

	// A flagged result carries score zero
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && bad_s3 |-> score_s3 == '0)
		else $error("bad letter result with nonzero score");

	// A result held by a stalled sink stays in the output register
	a_hold_s3: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !res.ready |=> valid_s3)
		else $error("held result lost");

endmodule

`default_nettype wire

// ----- test/pcps_test_pkg.sv -----
// Command and score types plus the score tracker for the column pair scorer test.
`timescale 1ns / 100ps

package pcps_test_pkg;
	import pcps_pkg::*;

	// Kinds the block ignores
	localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
	localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

	localparam int REPORT_LIMIT = 10;

	typedef struct {
		logic [KIND_W-1:0]   kind;
		logic [COL_W-1:0]    column_x;
		logic [COL_W-1:0]    column_y;
		logic [FEAT_W-1:0]   load_feature;
		logic [LETTER_W-1:0] load_row;
		logic [LETTER_W-1:0] load_col;
		logic [VALUE_W-1:0]  load_value;
	} cmd_item_t;

	typedef struct {
		logic signed [SCORE_W-1:0] score;
		logic                      bad_letter;
	} score_result_t;

	class score_tracker;
		logic [FC_W-1:0]     feature_count;
		logic [WEIGHT_W-1:0] weight [NUM_WEIGHTS];
		logic [VALUE_W-1:0]  odds_tab [MAX_FEATURES][ALPHABET_SIZE][ALPHABET_SIZE];
		logic [VALUE_W-1:0]  prob_tab [MAX_FEATURES][ALPHABET_SIZE][ALPHABET_SIZE];
		logic [VALUE_W-1:0]  ins_tab [MAX_FEATURES][ALPHABET_SIZE];
		score_result_t       pending_scores [$];
		int unsigned         errors;

		function new();
			feature_count = FC_RESET;
			foreach (weight[i])
				weight[i] = WEIGHT_RESET;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_FEATURE_COUNT: feature_count = data[FC_W-1:0];
				REG_WEIGHT_0:      weight[0] = data;
				REG_WEIGHT_1:      weight[1] = data;
				REG_WEIGHT_2:      weight[2] = data;
				REG_WEIGHT_3:      weight[3] = data;
				default:           ;
			endcase
		endfunction

		// Weighted sum over the active features, or a bad letter flag
		function score_result_t column_score(cmd_item_t c);
			score_result_t       r;
			int                  active;
			longint              sum;
			logic [LETTER_W-1:0] x;
			logic [LETTER_W-1:0] y;
			logic [VALUE_W-1:0]  raw;
			active = (int'(feature_count) < MAX_FEATURES) ? int'(feature_count) : MAX_FEATURES;
			sum = 0;
			r.bad_letter = 1'b0;
			for (int f = 0; f < active && !r.bad_letter; f++) begin
				x = c.column_x[LETTER_W*f +: LETTER_W];
				y = c.column_y[LETTER_W*f +: LETTER_W];
				if (x >= ALPHABET_SIZE || (c.kind != KIND_SCORE_INSERT && y >= ALPHABET_SIZE)) begin
					r.bad_letter = 1'b1;
				end else begin
					case (c.kind)
						KIND_SCORE_ODDS: raw = odds_tab[f][x][y];
						KIND_SCORE_PROB: raw = prob_tab[f][x][y];
						default:         raw = ins_tab[f][x];
					endcase
					sum += longint'($signed(raw)) * longint'(weight[f]);
				end
			end
			// Four features cannot leave the 34-bit range, so no clamp is needed
			if (r.bad_letter)
				sum = 0;
			r.score = sum[SCORE_W-1:0];
			return r;
		endfunction

		// Apply a load, or queue the score an accepted request must produce
		function void take_command(cmd_item_t c);
			bit pair_ok;
			pair_ok = c.load_row < ALPHABET_SIZE && c.load_col < ALPHABET_SIZE;
			case (c.kind)
				KIND_LOAD_ODDS: begin
					if (pair_ok) begin
						odds_tab[c.load_feature][c.load_row][c.load_col] = c.load_value;
						odds_tab[c.load_feature][c.load_col][c.load_row] = c.load_value;
					end
				end
				KIND_LOAD_PROB: begin
					if (pair_ok) begin
						prob_tab[c.load_feature][c.load_row][c.load_col] = c.load_value;
						prob_tab[c.load_feature][c.load_col][c.load_row] = c.load_value;
					end
				end
				KIND_LOAD_INSERT: begin
					if (c.load_row < ALPHABET_SIZE)
						ins_tab[c.load_feature][c.load_row] = c.load_value;
				end
				KIND_SCORE_ODDS, KIND_SCORE_PROB, KIND_SCORE_INSERT: begin
					pending_scores.insert(pending_scores.size(), column_score(c));
				end
				default: ;
			endcase
		endfunction

		// Compare one returned score with the oldest pending one
		function void compare_score(logic signed [SCORE_W-1:0] score, logic bad_letter);
			score_result_t e;
			if (pending_scores.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("unexpected score %0d bad_letter %0b, none pending", score, bad_letter);
				return;
			end
			e = pending_scores.pop_front();
			if (score !== e.score || bad_letter !== e.bad_letter) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("score mismatch: expected %0d bad_letter %0b, got %0d bad_letter %0b",
						e.score, e.bad_letter, score, bad_letter);
			end
		endfunction
	endclass

endpackage

// ----- test/profile_column_pair_scorer_test.sv -----
// Testbench for the column pair scorer: directed and random loads and scores, checked in order.
`timescale 1ns / 100ps

module profile_column_pair_scorer_test;
	import pcps_pkg::*;
	import pcps_test_pkg::*;

	localparam int HALF_PERIOD   = 5;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int LETTER_MAX    = (1 << LETTER_W) - 1;
	localparam int KEY_BASE      = 1 << LETTER_W;

	logic clk = 1'b0;
	logic arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pcps_in_if  cmd_ch ();
	pcps_out_if res_ch ();

	profile_column_pair_scorer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd_ch),
		.res       (res_ch)
	);

	score_tracker tracker = new();

	// Written entries per table and feature, as row * KEY_BASE + col
	int unsigned entry_keys [3][MAX_FEATURES][$];

	bit quiet = 1'b0;
	int stall_left = 0;
	int cycle_count = 0;

	always begin
		#(HALF_PERIOD) clk = 1'b1;
		#(HALF_PERIOD) clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Check returned scores and stall the result channel in bursts
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			tracker.compare_score(res_ch.score, res_ch.bad_letter);
		if (quiet) begin
			stall_left = 0;
			res_ch.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			res_ch.ready <= 1'b0;
		end else if ($urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(1, 5) - 1;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	function automatic region_t region_of(logic [KIND_W-1:0] kind);
		case (kind)
			KIND_LOAD_ODDS, KIND_SCORE_ODDS: return REGION_ODDS;
			KIND_LOAD_PROB, KIND_SCORE_PROB: return REGION_PROB;
			default:                         return REGION_INSERT;
		endcase
	endfunction

	function automatic cmd_item_t mk(logic [KIND_W-1:0] kind, logic [COL_W-1:0] cx,
			logic [COL_W-1:0] cy, logic [FEAT_W-1:0] lf, logic [LETTER_W-1:0] lr,
			logic [LETTER_W-1:0] lc, logic [VALUE_W-1:0] lv);
		cmd_item_t c;
		c.kind = kind;
		c.column_x = cx;
		c.column_y = cy;
		c.load_feature = lf;
		c.load_row = lr;
		c.load_col = lc;
		c.load_value = lv;
		return c;
	endfunction

	// Pack four letters, feature 0 lowest
	function automatic logic [COL_W-1:0] letters(int a, int b, int c, int d);
		return {LETTER_W'(d), LETTER_W'(c), LETTER_W'(b), LETTER_W'(a)};
	endfunction

	function automatic logic [VALUE_W-1:0] random_value();
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
		return VALUE_W'($urandom);
	endfunction

	function automatic logic [WEIGHT_W-1:0] random_weight();
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, 1) ? '1 : '0;
		return WEIGHT_W'($urandom);
	endfunction

	function automatic logic [LETTER_W-1:0] random_index();
		if ($urandom_range(0, 9) == 0)
			return LETTER_W'($urandom_range(ALPHABET_SIZE, LETTER_MAX));
		return LETTER_W'($urandom_range(0, ALPHABET_SIZE - 1));
	endfunction

	// Present one transaction, with an optional idle burst ahead of it
	task automatic send_cmd(cmd_item_t c);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid        <= 1'b1;
		cmd_ch.kind         <= c.kind;
		cmd_ch.column_x     <= c.column_x;
		cmd_ch.column_y     <= c.column_y;
		cmd_ch.load_feature <= c.load_feature;
		cmd_ch.load_row     <= c.load_row;
		cmd_ch.load_col     <= c.load_col;
		cmd_ch.load_value   <= c.load_value;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		tracker.take_command(c);
	endtask

	// Record entries that a load will write, then send it
	task automatic issue(cmd_item_t c);
		region_t rg;
		rg = region_of(c.kind);
		if (c.kind <= KIND_LOAD_INSERT && c.load_row < ALPHABET_SIZE) begin
			if (rg == REGION_INSERT)
				entry_keys[rg][c.load_feature].insert(entry_keys[rg][c.load_feature].size(),
					c.load_row * KEY_BASE);
			else if (c.load_col < ALPHABET_SIZE)
				entry_keys[rg][c.load_feature].insert(entry_keys[rg][c.load_feature].size(),
					c.load_row * KEY_BASE + c.load_col);
		end
		send_cmd(c);
	endtask

	// Score request built from written entries, sometimes with a bad letter
	task automatic score_random(logic [KIND_W-1:0] kind);
		cmd_item_t           c;
		region_t             rg;
		logic [KIND_W-1:0]   load_kind;
		int unsigned         key;
		logic [LETTER_W-1:0] row;
		logic [LETTER_W-1:0] col;
		int                  f_bad;
		rg = region_of(kind);
		load_kind = (rg == REGION_ODDS) ? KIND_LOAD_ODDS :
			(rg == REGION_PROB) ? KIND_LOAD_PROB : KIND_LOAD_INSERT;
		for (int f = 0; f < MAX_FEATURES; f++) begin
			if (entry_keys[rg][f].size() == 0)
				issue(mk(load_kind, '0, '0, FEAT_W'(f),
					LETTER_W'($urandom_range(0, ALPHABET_SIZE - 1)),
					LETTER_W'($urandom_range(0, ALPHABET_SIZE - 1)), random_value()));
		end
		c = mk(kind, '0, '0, FEAT_W'($urandom), LETTER_W'($urandom), LETTER_W'($urandom),
			VALUE_W'($urandom));
		for (int f = 0; f < MAX_FEATURES; f++) begin
			key = entry_keys[rg][f][$urandom_range(0, entry_keys[rg][f].size() - 1)];
			row = LETTER_W'(key / KEY_BASE);
			col = LETTER_W'(key % KEY_BASE);
			// Read through the mirrored entry half the time
			if (rg != REGION_INSERT && $urandom_range(0, 1) == 1) begin
				row = LETTER_W'(key % KEY_BASE);
				col = LETTER_W'(key / KEY_BASE);
			end
			c.column_x[LETTER_W*f +: LETTER_W] = row;
			c.column_y[LETTER_W*f +: LETTER_W] = (rg == REGION_INSERT) ? LETTER_W'($urandom) : col;
		end
		if ($urandom_range(0, 9) == 0) begin
			f_bad = $urandom_range(0, MAX_FEATURES - 1);
			if (rg == REGION_INSERT || $urandom_range(0, 1) == 0)
				c.column_x[LETTER_W*f_bad +: LETTER_W] =
					LETTER_W'($urandom_range(ALPHABET_SIZE, LETTER_MAX));
			else
				c.column_y[LETTER_W*f_bad +: LETTER_W] =
					LETTER_W'($urandom_range(ALPHABET_SIZE, LETTER_MAX));
		end
		issue(c);
	endtask

	task automatic random_items(int n);
		int pick;
		repeat (n) begin
			pick = $urandom_range(0, 99);
			if (pick < 35)
				issue(mk(KIND_W'($urandom_range(KIND_LOAD_ODDS, KIND_LOAD_INSERT)),
					COL_W'($urandom), COL_W'($urandom), FEAT_W'($urandom),
					random_index(), random_index(), random_value()));
			else if (pick < 95)
				score_random(KIND_W'($urandom_range(KIND_SCORE_ODDS, KIND_SCORE_INSERT)));
			else
				issue(mk(KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)),
					COL_W'($urandom), COL_W'($urandom), FEAT_W'($urandom),
					LETTER_W'($urandom), LETTER_W'($urandom), VALUE_W'($urandom)));
		end
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		tracker.write_reg(idx, data);
	endtask

	// Write every register, plus one unmapped index that must do nothing
	task automatic configure(logic [FC_W-1:0] count, logic [WEIGHT_W-1:0] w [NUM_WEIGHTS]);
		cfg_write(REG_FEATURE_COUNT, CFG_DATA_W'(count));
		cfg_write(REG_WEIGHT_0, w[0]);
		cfg_write(REG_WEIGHT_1, w[1]);
		cfg_write(REG_WEIGHT_2, w[2]);
		cfg_write(REG_WEIGHT_3, w[3]);
		cfg_write(CFG_IDX_W'($urandom_range(REG_WEIGHT_3 + 1, (1 << CFG_IDX_W) - 1)),
			CFG_DATA_W'($urandom));
		cfg_wr_en <= 1'b0;
	endtask

	// Drain all pending scores, then let the pipeline empty
	task automatic settle();
		cmd_ch.valid <= 1'b0;
		while (tracker.pending_scores.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [WEIGHT_W-1:0] wset [NUM_WEIGHTS];
		logic [FC_W-1:0]     count;
		arst_n              <= 1'b0;
		cfg_wr_en           <= 1'b0;
		cfg_index           <= '0;
		cfg_data            <= '0;
		cmd_ch.valid        <= 1'b0;
		cmd_ch.kind         <= '0;
		cmd_ch.column_x     <= '0;
		cmd_ch.column_y     <= '0;
		cmd_ch.load_feature <= '0;
		cmd_ch.load_row     <= '0;
		cmd_ch.load_col     <= '0;
		cmd_ch.load_value   <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset registers: one feature at weight 1.0
		issue(mk(KIND_LOAD_ODDS, '0, '0, 0, 0, 19, 16'h7FFF));
		issue(mk(KIND_LOAD_PROB, '0, '0, 0, 19, 0, 16'h8000));
		issue(mk(KIND_LOAD_INSERT, '0, '0, 0, 19, LETTER_MAX, 16'h8000));
		issue(mk(KIND_LOAD_ODDS, '0, '0, 0, 5, 5, 16'h0100));
		issue(mk(KIND_LOAD_ODDS, '0, '0, 0, ALPHABET_SIZE, 3, 16'h1234));
		issue(mk(KIND_LOAD_PROB, '0, '0, 0, 2, LETTER_MAX, 16'h4321));
		issue(mk(KIND_SCORE_ODDS, letters(19, 31, 31, 31), letters(0, 31, 31, 31), 0, 0, 0, 0));
		issue(mk(KIND_SCORE_PROB, letters(0, 31, 31, 31), letters(19, 31, 31, 31), 0, 0, 0, 0));
		issue(mk(KIND_SCORE_INSERT, letters(19, 31, 31, 31), '1, 0, 0, 0, 0));
		issue(mk(KIND_SCORE_ODDS, letters(5, 31, 31, 31), letters(5, 31, 31, 31), 0, 0, 0, 0));
		issue(mk(KIND_SCORE_ODDS, letters(25, 0, 0, 0), letters(0, 0, 0, 0), 0, 0, 0, 0));
		issue(mk(KIND_SCORE_PROB, letters(0, 0, 0, 0), letters(20, 0, 0, 0), 0, 0, 0, 0));
		issue(mk(KIND_SPARE_LO, '1, '1, '1, '1, '1, '1));
		issue(mk(KIND_SPARE_HI, '0, '0, 0, 0, 0, 0));
		settle();

		// All four features at the largest weight: extreme sums
		foreach (wset[i])
			wset[i] = '1;
		configure(FC_W'(MAX_FEATURES), wset);
		for (int f = 1; f < MAX_FEATURES; f++)
			issue(mk(KIND_LOAD_ODDS, '0, '0, FEAT_W'(f), 0, 19, 16'h7FFF));
		for (int f = 1; f < MAX_FEATURES; f++)
			issue(mk(KIND_LOAD_PROB, '0, '0, FEAT_W'(f), 19, 0, 16'h8000));
		issue(mk(KIND_SCORE_ODDS, letters(19, 19, 19, 19), letters(0, 0, 0, 0), 0, 0, 0, 0));
		issue(mk(KIND_SCORE_PROB, letters(0, 0, 0, 0), letters(19, 19, 19, 19), 0, 0, 0, 0));
		issue(mk(KIND_SCORE_ODDS, letters(19, 19, 19, 19), letters(0, 0, 20, 0), 0, 0, 0, 0));
		random_items(150);
		settle();

		// Random phases; the last one runs with no idling
		for (int p = 2; p <= 9; p++) begin
			foreach (wset[i])
				wset[i] = (p == 3) ? '0 : random_weight();
			if (p == 2)
				count = '0;
			else if (p == 3)
				count = '1;
			else if (p == 9)
				count = FC_W'(MAX_FEATURES);
			else
				count = FC_W'($urandom_range(1, (1 << FC_W) - 1));
			configure(count, wset);
			quiet = (p == 9);
			random_items(200);
			settle();
		end

		if (tracker.errors == 0 && tracker.pending_scores.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
